### rtl/i2cm_pkg.sv
package i2cm_pkg;

    // Opcodes on the input stream (tuser)
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_WBYTE = 2'd2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] SHIFT_IDLE = 8'hff;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_START,
        CMD_WBYTE,
        CMD_NOP
    } cmd_kind_t;

    // Classified command handed from the front queue to the bus engine
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data_byte;
        logic [7:0] length;     // zero already mapped to one
        logic       scl_in;
        logic       sda_in;
    } cmd_t;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_HELD     = 5'd1,
        PH_ST_WAIT  = 5'd2,
        PH_ST_HOLD  = 5'd3,
        PH_ST_SDA   = 5'd4,
        PH_BIT_LOW  = 5'd5,
        PH_BIT_WAIT = 5'd6,
        PH_BIT_HIGH = 5'd7,
        PH_WANT     = 5'd8,
        PH_SP_LOW   = 5'd9,
        PH_SP_WAIT  = 5'd10,
        PH_SP_HOLD  = 5'd11,
        PH_SP_END   = 5'd12
    } phase_t;

    // Result word, last member in the lowest bits
    typedef struct packed {
        logic       error;
        logic       done_res;
        logic       busy_res;
        logic [7:0] read_data;
        logic       read_valid;
        logic       want_byte;
        logic       sda_drive_low;
        logic       scl_drive_low;
    } res_t;

    // SDA drive for the current bit slot: data bits, then the acknowledge slot
    function automatic logic bit_sda_low(input logic [3:0] bit_count,
                                         input logic       msb,
                                         input logic       writing,
                                         input logic [7:0] bytes_left);
        logic low;
        if (bit_count < 4'd8)
            low = writing & ~msb;
        else if (writing)
            low = 1'b0;
        else
            low = (bytes_left != 8'd1);
        return low;
    endfunction

endpackage

### rtl/i2cm_front.sv
module i2cm_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [i2cm_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [1:0]                        s_tuser,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output i2cm_pkg::cmd_t                    cmd
);
    import i2cm_pkg::*;

    cmd_t       entry_mem [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cmd_in;
    logic       push, pop;

    // Classify the incoming transaction
    always_comb
    begin
        cmd_in.data_byte = s_tdata[7:0];
        cmd_in.length    = (s_tdata[15:8] == 8'd0) ? 8'd1 : s_tdata[15:8];
        cmd_in.scl_in    = s_tdata[16];
        cmd_in.sda_in    = s_tdata[17];
        case (s_tuser)
            OP_TICK:  cmd_in.kind = CMD_TICK;
            OP_START: cmd_in.kind = CMD_START;
            OP_WBYTE: cmd_in.kind = CMD_WBYTE;
            default:  cmd_in.kind = CMD_NOP;
        endcase
    end

    assign s_tready  = (count_reg != 2'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != 2'd0);
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = entry_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_mem[wr_ptr_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'(QUEUE_DEPTH)) && !pop |=> (count_reg == 2'(QUEUE_DEPTH)))
        else $error("full queue changed without a pop");

endmodule

### rtl/i2cm_engine.sv
module i2cm_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  i2cm_pkg::cmd_t                cmd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output i2cm_pkg::res_t                res
);
    import i2cm_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] shift_reg, shift_next;
    logic       read_mode_reg, read_mode_next;
    logic       address_sent_reg, address_sent_next;
    logic       m_tvalid_reg, m_tvalid_next;
    res_t       res_reg, res_next;
    logic       take;
    logic       writing, writing_next, sda_bit;

    assign cmd_ready = !m_tvalid_reg || m_tready;
    assign take      = cmd_valid && cmd_ready;
    assign writing   = !address_sent_reg || !read_mode_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        bytes_left_next   = bytes_left_reg;
        shift_next        = shift_reg;
        read_mode_next    = read_mode_reg;
        address_sent_next = address_sent_reg;
        res_next          = '0;

        case (cmd.kind)
            CMD_START:
            begin
                if (phase_reg == PH_IDLE || phase_reg == PH_HELD)
                begin
                    shift_next        = cmd.data_byte;
                    read_mode_next    = cmd.data_byte[0];
                    bytes_left_next   = cmd.length;
                    address_sent_next = 1'b0;
                    bit_count_next    = 4'd0;
                    phase_next        = PH_ST_WAIT;
                end
            end
            CMD_WBYTE:
            begin
                if (phase_reg == PH_WANT)
                begin
                    shift_next     = cmd.data_byte;
                    bit_count_next = 4'd0;
                    phase_next     = PH_BIT_LOW;
                end
            end
            CMD_TICK:
            begin
                case (phase_reg)
                    PH_ST_WAIT:  if (cmd.scl_in) phase_next = PH_ST_HOLD;
                    PH_ST_HOLD:  phase_next = PH_ST_SDA;
                    PH_ST_SDA:
                    begin
                        bit_count_next = 4'd0;
                        phase_next     = PH_BIT_LOW;
                    end
                    PH_BIT_LOW:  phase_next = PH_BIT_WAIT;
                    PH_BIT_WAIT: if (cmd.scl_in) phase_next = PH_BIT_HIGH;
                    PH_BIT_HIGH:
                    begin
                        if (bit_count_reg < 4'd8)
                        begin
                            // shift in, MSB first
                            shift_next = {shift_reg[6:0], cmd.sda_in};
                            if (bit_count_reg == 4'd7 && !writing)
                            begin
                                res_next.read_valid = 1'b1;
                                res_next.read_data  = shift_next;
                            end
                            bit_count_next = bit_count_reg + 4'd1;
                            phase_next     = PH_BIT_LOW;
                        end
                        else
                        begin
                            bit_count_next = 4'd0;
                            if (writing && cmd.sda_in)
                            begin
                                // NACK on a written byte: abort, hold SCL low
                                res_next.done_res = 1'b1;
                                res_next.error    = 1'b1;
                                bytes_left_next   = 8'd0;
                                phase_next        = PH_HELD;
                            end
                            else
                            begin
                                if (writing)
                                    address_sent_next = 1'b1;
                                bytes_left_next = bytes_left_reg - 8'd1;
                                if (bytes_left_next == 8'd0)
                                    phase_next = PH_SP_LOW;
                                else if (!read_mode_reg)
                                    phase_next = PH_WANT;
                                else
                                begin
                                    shift_next = SHIFT_IDLE;
                                    phase_next = PH_BIT_LOW;
                                end
                            end
                        end
                    end
                    PH_SP_LOW:   phase_next = PH_SP_WAIT;
                    PH_SP_WAIT:  if (cmd.scl_in) phase_next = PH_SP_HOLD;
                    PH_SP_HOLD:  phase_next = PH_SP_END;
                    PH_SP_END:
                    begin
                        phase_next        = PH_IDLE;
                        res_next.done_res = 1'b1;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
            default: phase_next = phase_reg;
        endcase

        // Line drive follows the updated phase
        writing_next = !address_sent_next || !read_mode_next;
        sda_bit = bit_sda_low(bit_count_next, shift_next[7], writing_next, bytes_left_next);
        case (phase_next)
            PH_HELD:     res_next.scl_drive_low = 1'b1;
            PH_ST_SDA:   res_next.sda_drive_low = 1'b1;
            PH_BIT_LOW:
            begin
                res_next.scl_drive_low = 1'b1;
                res_next.sda_drive_low = sda_bit;
            end
            PH_BIT_WAIT,
            PH_BIT_HIGH: res_next.sda_drive_low = sda_bit;
            PH_WANT:     res_next.scl_drive_low = 1'b1;
            PH_SP_LOW:
            begin
                res_next.scl_drive_low = 1'b1;
                res_next.sda_drive_low = 1'b1;
            end
            PH_SP_WAIT,
            PH_SP_HOLD:  res_next.sda_drive_low = 1'b1;
            default:     res_next.scl_drive_low = 1'b0;
        endcase
        res_next.want_byte = (phase_next == PH_WANT);
        res_next.busy_res  = (phase_next >= PH_ST_WAIT);

        m_tvalid_next = take || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= 4'd0;
            bytes_left_reg   <= 8'd0;
            shift_reg        <= SHIFT_IDLE;
            read_mode_reg    <= 1'b0;
            address_sent_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (take)
            begin
                phase_reg        <= phase_next;
                bit_count_reg    <= bit_count_next;
                bytes_left_reg   <= bytes_left_next;
                shift_reg        <= shift_next;
                read_mode_reg    <= read_mode_next;
                address_sent_reg <= address_sent_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign res      = res_reg;

    a_err_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && res_reg.error |-> res_reg.done_res)
        else $error("error flagged without done");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= 4'd8)
        else $error("bit counter past acknowledge slot");

    a_want_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WANT) |-> (bit_count_reg == 4'd0) && !read_mode_reg)
        else $error("waiting for write byte in a bad state");

    a_cmd_no_timing: assert property (@(posedge clk) disable iff (!rst_n)
        take && (cmd.kind != CMD_TICK) && (phase_reg != PH_IDLE)
        && (phase_reg != PH_HELD) && (phase_reg != PH_WANT)
        |=> (phase_reg == $past(phase_reg)))
        else $error("non-tick command moved bus timing");

    a_read_in_read_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && res_reg.read_valid |-> read_mode_reg)
        else $error("read byte reported in write transaction");

endmodule

### rtl/i2c_master_transaction.sv
// I2C master transaction engine driven by quarter-bit ticks.
//
// Input stream (s_*): one transaction per command. s_tuser carries the opcode
// (tick, start, supply write byte); s_tdata carries the address or write byte,
// the byte count (address included, zero counts as one) and the sampled SCL and
// SDA levels. Every input transaction yields exactly one result transaction on
// the output stream (m_*): open-drain drive levels for SCL/SDA, a request for the
// next write byte, a received read byte, and busy/done/error status.
//
// Path: an accepted input passes through the two-entry command queue and then
// the bus engine's output register before its result appears.
// Throughput: one transaction per clock while m_tready stays high; the queue
// keeps s_tready high while a result waits, until it holds two commands.
//
// Reset: the engine returns to idle; the queue empties.
// When the receiver stalls (m_tready low) the engine holds its result and state,
// the queue fills up to two commands, and then s_tready drops.
module i2c_master_transaction (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] data_byte, [15:8] length, [16] scl_in, [17] sda_in, [23:18] zero
    input  logic [23:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] scl_drive_low, [1] sda_drive_low, [2] want_byte, [3] read_valid,
    // [11:4] read_data, [12] busy_res, [13] done_res, [14] error, [15] zero
    output logic [15:0] m_tdata
);
    import i2cm_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;
    res_t res;

    // Front: classify commands and buffer them
    i2cm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back: bus sequencer with registered result
    i2cm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res       (res)
    );

    // Pad the result word up to whole bytes
    assign m_tdata = {1'b0, res};

endmodule
